[design/wide_scaled_mantissa_alu_macros.svh]
// assertion macros for the checker
`ifndef WIDE_SCALED_MANTISSA_ALU_MACROS_SVH
`define WIDE_SCALED_MANTISSA_ALU_MACROS_SVH

// a implies b on the same edge
`define WSMA_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("check failed");

// a implies b on the next edge
`define WSMA_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("check failed");

`endif

[design/wsma_pkg.sv]
`default_nettype none
package wsma_pkg;
  localparam int unsigned MagBits = 192;
  localparam int unsigned CntW = 8;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_CMP = 3'd4,
    FUNC_POW = 3'd5
  } func_e;

  localparam logic [1:0] OrderEq = 2'd0;
  localparam logic [1:0] OrderGt = 2'd1;
  localparam logic [1:0] OrderLt = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] a_word0;
    logic [63:0] a_word1;
    logic [63:0] a_word2;
    logic        a_negative;
    logic signed [7:0] a_scale;
    logic [63:0] b_word0;
    logic [63:0] b_word1;
    logic [63:0] b_word2;
    logic        b_negative;
    logic signed [7:0] b_scale;
    logic [31:0] power_n;
  } req_t;

  typedef struct packed {
    logic [63:0] res_word0;
    logic [63:0] res_word1;
    logic [63:0] res_word2;
    logic        res_negative;
    logic signed [7:0] res_scale;
    logic [63:0] rem_word0;
    logic [63:0] rem_word1;
    logic [63:0] rem_word2;
    logic        rem_negative;
    logic signed [7:0] rem_scale;
    logic [1:0]  order;
    logic        overflow;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic quick;     // add, sub, compare, unknown into result
    logic mul_init;  // start a multiply: a x b, prod x mult or mult x mult
    logic mul_sq;    // in power, 1 squares mult, 0 multiplies prod by mult
    logic mul_step;
    logic mul_done;  // write product back
    logic div_init;
    logic div_step;
    logic div_done;
    logic pow_fin;
    logic exp_dec;
    logic exp_half;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       exp_zero;
    logic       exp_odd;
    logic       cnt_last;
  } sts_t;
endpackage
`default_nettype wire

[design/wsma_ctrl.sv]
`default_nettype none
module wsma_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  output logic                done_o,
  input  wire wsma_pkg::sts_t sts_i,
  output wsma_pkg::cmd_t      cmd_o
);
  import wsma_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DISP = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_MWB  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_PSEL = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   pow_q, pow_d;
  logic   sq_q, sq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pow_q   <= 1'b0;
      sq_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pow_q   <= pow_d;
      sq_q    <= sq_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pow_d   = pow_q;
    sq_d    = sq_q;
    cmd_o   = '0;
    cmd_o.mul_sq = sq_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.func)
          FUNC_MUL: begin
            cmd_o.mul_init = 1'b1;
            cmd_o.mul_sq   = 1'b0;
            sq_d  = 1'b0;
            pow_d = 1'b0;
            state_d = S_MUL;
          end
          FUNC_DIV: begin
            cmd_o.div_init = 1'b1;
            state_d = S_DIV;
          end
          FUNC_POW: begin
            pow_d = 1'b1;
            state_d = S_PSEL;
          end
          default: begin
            cmd_o.quick = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_PSEL: begin
        if (sts_i.exp_zero) begin
          cmd_o.pow_fin = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.mul_init = 1'b1;
          cmd_o.mul_sq   = !sts_i.exp_odd;
          sq_d = !sts_i.exp_odd;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) state_d = S_MWB;
      end
      S_MWB: begin
        cmd_o.mul_done = 1'b1;
        if (pow_q) begin
          cmd_o.exp_dec  = !sq_q;
          cmd_o.exp_half = sq_q;
          state_d = S_PSEL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.div_done = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
endmodule
`default_nettype wire

[design/wsma_dpath.sv]
`default_nettype none
module wsma_dpath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire wsma_pkg::req_t req_i,
  input  wire wsma_pkg::cmd_t cmd_i,
  output wsma_pkg::sts_t      sts_o,
  output wsma_pkg::rsp_t      rsp_o
);
  import wsma_pkg::*;

  logic [MagBits-1:0] a_q, b_q;
  logic               an_q, bn_q;
  logic [7:0]         as_q, bs_q;
  logic [2:0]         func_q;
  logic [31:0]        n_q, e_q;
  logic [MagBits-1:0] prod_q, mult_q;
  // shift-add multiplier: x shifts right, y shifts left
  logic [MagBits-1:0] mx_q, my_q, acc_q;
  logic               my_ov_q, mov_q, pov_q;
  // divider
  logic [MagBits-1:0] rem_q, quo_q, dvd_q;
  logic [CntW-1:0]    cnt_q;
  rsp_t               rsp_q, rsp_d;

  logic [MagBits:0]   acc_sum;
  logic [MagBits:0]   rem_sh, rem_sub;
  logic [MagBits-1:0] add_r, sub_r;
  logic [1:0]         ord;

  assign acc_sum = {1'b0, acc_q} + {1'b0, my_q};
  assign rem_sh  = {rem_q, dvd_q[MagBits-1]};
  assign rem_sub = rem_sh - {1'b0, b_q};
  assign add_r   = a_q + b_q;
  assign sub_r   = a_q - b_q;
  assign ord     = (a_q > b_q) ? OrderGt : ((a_q < b_q) ? OrderLt : OrderEq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mul_init || cmd_i.div_init) begin
      cnt_q <= CntW'(MagBits - 1);
    end else if (cmd_i.mul_step || cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.quick) begin
      rsp_d = '0;
      case (func_q)
        FUNC_ADD: begin
          {rsp_d.res_word2, rsp_d.res_word1, rsp_d.res_word0} = add_r;
          rsp_d.res_negative = an_q;
          rsp_d.res_scale    = as_q;
        end
        FUNC_SUB: begin
          {rsp_d.res_word2, rsp_d.res_word1, rsp_d.res_word0} = sub_r;
          rsp_d.res_negative = an_q;
          rsp_d.res_scale    = as_q;
        end
        FUNC_CMP: rsp_d.order = ord;
        default: ;
      endcase
    end
    if (cmd_i.mul_done && func_q == FUNC_MUL) begin
      rsp_d = '0;
      {rsp_d.res_word2, rsp_d.res_word1, rsp_d.res_word0} = acc_q;
      rsp_d.res_negative = an_q ^ bn_q;
      rsp_d.res_scale    = as_q + bs_q;
      rsp_d.overflow     = mov_q;
    end
    if (cmd_i.pow_fin) begin
      rsp_d = '0;
      {rsp_d.res_word2, rsp_d.res_word1, rsp_d.res_word0} = prod_q;
      rsp_d.res_negative = an_q & n_q[0];
      rsp_d.res_scale    = 8'(as_q * n_q[7:0]);
      rsp_d.overflow     = pov_q;
    end
    if (cmd_i.div_done) begin
      rsp_d = '0;
      if (rem_sh[MagBits] || !rem_sub[MagBits]) begin
        {rsp_d.res_word2, rsp_d.res_word1, rsp_d.res_word0} = {quo_q[MagBits-2:0], 1'b1};
        {rsp_d.rem_word2, rsp_d.rem_word1, rsp_d.rem_word0} = rem_sub[MagBits-1:0];
      end else begin
        {rsp_d.res_word2, rsp_d.res_word1, rsp_d.res_word0} = {quo_q[MagBits-2:0], 1'b0};
        {rsp_d.rem_word2, rsp_d.rem_word1, rsp_d.rem_word0} = rem_sh[MagBits-1:0];
      end
      rsp_d.res_negative = an_q ^ bn_q;
      rsp_d.res_scale    = as_q - bs_q;
      rsp_d.rem_negative = an_q ^ bn_q;
      rsp_d.rem_scale    = as_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= {req_i.a_word2, req_i.a_word1, req_i.a_word0};
      b_q    <= {req_i.b_word2, req_i.b_word1, req_i.b_word0};
      an_q   <= req_i.a_negative;
      bn_q   <= req_i.b_negative;
      as_q   <= req_i.a_scale;
      bs_q   <= req_i.b_scale;
      func_q <= req_i.func;
      n_q    <= req_i.power_n;
      e_q    <= req_i.power_n;
      prod_q <= MagBits'(1);
      mult_q <= {req_i.a_word2, req_i.a_word1, req_i.a_word0};
      pov_q  <= 1'b0;
    end
    if (cmd_i.mul_init) begin
      mx_q    <= (func_q == FUNC_MUL) ? a_q : (cmd_i.mul_sq ? mult_q : prod_q);
      my_q    <= (func_q == FUNC_MUL) ? b_q : mult_q;
      acc_q   <= '0;
      my_ov_q <= 1'b0;
      mov_q   <= 1'b0;
    end
    if (cmd_i.mul_step) begin
      if (mx_q[0]) begin
        acc_q <= acc_sum[MagBits-1:0];
        if (acc_sum[MagBits] || my_ov_q) mov_q <= 1'b1;
      end
      mx_q    <= mx_q >> 1;
      my_q    <= my_q << 1;
      // bits shifted out of y matter only if a later x bit is set
      my_ov_q <= my_ov_q | my_q[MagBits-1];
    end
    if (cmd_i.mul_done) begin
      if (cmd_i.exp_half) mult_q <= acc_q;
      else prod_q <= acc_q;
      if (mov_q) pov_q <= 1'b1;
    end
    if (cmd_i.exp_dec)  e_q <= e_q - 1'b1;
    if (cmd_i.exp_half) e_q <= e_q >> 1;
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= a_q;
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      if (rem_sh[MagBits] || !rem_sub[MagBits]) begin
        rem_q <= rem_sub[MagBits-1:0];
        quo_q <= {quo_q[MagBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[MagBits-1:0];
        quo_q <= {quo_q[MagBits-2:0], 1'b0};
      end
    end
    rsp_q <= rsp_d;
  end

  assign sts_o.func     = func_q;
  assign sts_o.exp_zero = (e_q == '0);
  assign sts_o.exp_odd  = e_q[0];
  assign sts_o.cnt_last = (cnt_q == '0);
  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

[design/wide_scaled_mantissa_alu.sv]
`default_nettype none
// Multiprecision 192-bit ALU. Start an item with start while busy is low; the
// result appears on rsp_o while done_o is high for a single cycle, and cannot be
// stalled. Add, subtract, compare and unknown codes finish in the dispatch state;
// multiply and divide run one bit per cycle through separate shift/add and
// shift/subtract datapaths that share one bit counter; power runs one multiply
// per exponent step (square-and-multiply), one step per set bit of n plus one
// per bit below its top bit.
module wide_scaled_mantissa_alu (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire wsma_pkg::req_t req_i,
  output logic                done_o,
  output wsma_pkg::rsp_t      rsp_o
);
  import wsma_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wsma_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .done_o, .sts_i(sts), .cmd_o(cmd)
  );

  wsma_dpath u_dpath (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );
endmodule
`default_nettype wire

[design/wsma_checker.sv]
`default_nettype none
`include "wide_scaled_mantissa_alu_macros.svh"
module wsma_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire wsma_pkg::rsp_t rsp_o
);
  import wsma_pkg::*;

  // an accepted item makes the block busy
  `WSMA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  // done lasts one cycle and frees the block
  `WSMA_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o && !busy)
  `WSMA_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy)
  // order code never reserved value
  `WSMA_ASSERT_IMP(a_order, clk_i, rst_ni, done_o, rsp_o.order != 2'd3)
endmodule

bind wide_scaled_mantissa_alu wsma_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o
);
`default_nettype wire

[tb/tb_wsma_checker.sv]
module tb_wsma_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  wsma_pkg::req_t  req_i,
  input  logic            done_o,
  input  wsma_pkg::rsp_t  rsp_o,
  output int              fail_cnt_o,
  output int              pending_o
);
  import wsma_pkg::*;

  rsp_t expected_rsp_q[$];
  int   fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = expected_rsp_q.size();

  // low 192 bits of a*b, flag set when the product is wider
  function automatic logic [191:0] mag_mul(input logic [191:0] a, input logic [191:0] b,
                                           inout logic ovf);
    logic [383:0] p;
    p = {192'd0, a} * {192'd0, b};
    if (p[383:192] != '0) ovf = 1'b1;
    return p[191:0];
  endfunction

  function automatic rsp_t alu_predict(input req_t rq);
    rsp_t r;
    logic [191:0] a, b, q, base, acc;
    logic [192:0] rm;
    logic [31:0] e;
    logic [39:0] sp;
    logic ovf;
    r = '0;
    a = {rq.a_word2, rq.a_word1, rq.a_word0};
    b = {rq.b_word2, rq.b_word1, rq.b_word0};
    q = '0;
    ovf = 1'b0;
    case (rq.func)
      FUNC_ADD, FUNC_SUB: begin
        q = (rq.func == FUNC_ADD) ? a + b : a - b;
        r.res_negative = rq.a_negative;
        r.res_scale = rq.a_scale;
      end
      FUNC_MUL: begin
        q = mag_mul(a, b, ovf);
        r.overflow = ovf;
        r.res_negative = rq.a_negative ^ rq.b_negative;
        r.res_scale = rq.a_scale + rq.b_scale;
      end
      FUNC_DIV: begin
        // restoring divide, zero divisor yields all ones and remainder a
        rm = '0;
        for (int i = 191; i >= 0; i--) begin
          rm = {rm[191:0], a[i]};
          if (rm >= {1'b0, b}) begin
            rm = rm - {1'b0, b};
            q[i] = 1'b1;
          end
        end
        r.res_negative = rq.a_negative ^ rq.b_negative;
        r.res_scale = rq.a_scale - rq.b_scale;
        {r.rem_word2, r.rem_word1, r.rem_word0} = rm[191:0];
        r.rem_negative = rq.a_negative ^ rq.b_negative;
        r.rem_scale = rq.a_scale;
      end
      FUNC_CMP: begin
        r.order = (a > b) ? OrderGt : ((a < b) ? OrderLt : OrderEq);
      end
      FUNC_POW: begin
        acc = 192'd1;
        base = a;
        e = rq.power_n;
        while (e != 0) begin
          if (e[0]) begin
            acc = mag_mul(acc, base, ovf);
            e = e - 1;
          end else begin
            base = mag_mul(base, base, ovf);
            e = e >> 1;
          end
        end
        q = acc;
        r.overflow = ovf;
        r.res_negative = rq.a_negative & rq.power_n[0];
        sp = {32'd0, rq.a_scale} * {8'd0, rq.power_n};
        r.res_scale = sp[7:0];
      end
      default: ;
    endcase
    if (rq.func != FUNC_CMP) {r.res_word2, r.res_word1, r.res_word0} = q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  initial fail_cnt = 0;

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (start && !busy) expected_rsp_q.push_back(alu_predict(req_i));
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no item outstanding");
          fail_cnt++;
        end else begin
          e = expected_rsp_q.pop_front();
          check_field("res_word0", e.res_word0, rsp_o.res_word0);
          check_field("res_word1", e.res_word1, rsp_o.res_word1);
          check_field("res_word2", e.res_word2, rsp_o.res_word2);
          check_field("res_negative", e.res_negative, rsp_o.res_negative);
          check_field("res_scale", e.res_scale, rsp_o.res_scale);
          check_field("rem_word0", e.rem_word0, rsp_o.rem_word0);
          check_field("rem_word1", e.rem_word1, rsp_o.rem_word1);
          check_field("rem_word2", e.rem_word2, rsp_o.rem_word2);
          check_field("rem_negative", e.rem_negative, rsp_o.rem_negative);
          check_field("rem_scale", e.rem_scale, rsp_o.rem_scale);
          check_field("order", e.order, rsp_o.order);
          check_field("overflow", e.overflow, rsp_o.overflow);
        end
      end
    end
  end
endmodule

[tb/tb.sv]
module tb;
  import wsma_pkg::*;

  localparam logic [2:0] FuncRsv6 = 3'd6;
  localparam logic [2:0] FuncRsv7 = 3'd7;
  localparam int NumRandom = 1200;
  localparam int IdleLimit = 100000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;
  int fail_cnt, pending;
  int idle_pct = 0;
  int quiet_cycles = 0;
  bit timed_out = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  wide_scaled_mantissa_alu u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  tb_wsma_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // watchdog on cycles with no item and no result moving
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit && !timed_out) begin
      timed_out = 1;
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [191:0] rand_mag();
    logic [191:0] m;
    for (int i = 0; i < 6; i++) m[32*i +: 32] = $urandom;
    case ($urandom_range(0, 7))
      0: m = '0;
      1: m = '1;
      2: m[191:64] = '0;
      3: m = m & ({192{1'b1}} >> $urandom_range(1, 191));
      4: m[191:128] = '0;
      default: ;
    endcase
    return m;
  endfunction

  task automatic send(input req_t rq);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_op(input logic [2:0] f, input logic [191:0] a, input logic [191:0] b,
                         input logic [31:0] n, input logic an, input logic bn,
                         input logic [7:0] as, input logic [7:0] bs);
    req_t rq;
    rq.func = f;
    {rq.a_word2, rq.a_word1, rq.a_word0} = a;
    {rq.b_word2, rq.b_word1, rq.b_word0} = b;
    rq.a_negative = an;
    rq.b_negative = bn;
    rq.a_scale = as;
    rq.b_scale = bs;
    rq.power_n = n;
    send(rq);
  endtask

  initial begin
    logic [2:0] f;
    logic [31:0] n;
    logic [191:0] a, b;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: wraps, overflow, zero divisor, ties, power corners, reserved codes
    send_op(FUNC_ADD, '1, 192'd1, 0, 1, 0, 8'h7f, 8'h80);
    send_op(FUNC_ADD, '0, '0, 0, 0, 1, 8'h80, 8'h7f);
    send_op(FUNC_SUB, '0, 192'd1, 0, 0, 1, 8'h80, 8'h01);
    send_op(FUNC_SUB, {64'd1, 64'd0, 64'd0}, 192'd1, 0, 1, 1, 8'h00, 8'h00);
    send_op(FUNC_MUL, '1, '1, 0, 1, 1, 8'h7f, 8'h7f);
    send_op(FUNC_MUL, 192'd1 << 96, 192'd1 << 96, 0, 1, 0, 8'h80, 8'h80);
    send_op(FUNC_MUL, 192'd1 << 95, 192'd1 << 96, 0, 0, 1, 8'h01, 8'hff);
    send_op(FUNC_MUL, '0, '1, 0, 0, 0, 8'h00, 8'h00);
    send_op(FUNC_DIV, '1, '0, 0, 1, 0, 8'h80, 8'h7f);
    send_op(FUNC_DIV, '1, 192'd3, 0, 0, 1, 8'h7f, 8'h80);
    send_op(FUNC_DIV, 192'd5, '1, 0, 1, 1, 8'h05, 8'h03);
    send_op(FUNC_DIV, '1, '1, 0, 0, 0, 8'h00, 8'h01);
    send_op(FUNC_CMP, '1, '1, 0, 1, 0, 8'h10, 8'h20);
    send_op(FUNC_CMP, '1, '1 >> 1, 0, 0, 0, 8'h00, 8'h00);
    send_op(FUNC_CMP, 192'd0, 192'd1, 0, 0, 0, 8'h00, 8'h00);
    send_op(FUNC_POW, '1, '0, 32'd0, 1, 0, 8'h7f, 8'h00);
    send_op(FUNC_POW, 192'd7, '0, 32'd1, 1, 0, 8'h80, 8'h00);
    send_op(FUNC_POW, 192'd2, '0, 32'd191, 1, 0, 8'h03, 8'h00);
    send_op(FUNC_POW, 192'd2, '0, 32'd192, 1, 0, 8'h03, 8'h00);
    send_op(FUNC_POW, 192'd3, '0, '1, 1, 1, 8'hff, 8'h00);
    send_op(FUNC_POW, '1, '0, 32'h80000000, 0, 0, 8'h7f, 8'h00);
    send_op(FuncRsv6, '1, '1, '1, 1, 1, 8'h7f, 8'h80);
    send_op(FuncRsv7, '1, '1, '1, 1, 1, 8'h80, 8'h7f);

    for (int i = 0; i < NumRandom; i++) begin
      case (i * 4 / NumRandom)
        0: idle_pct = 0;
        1: idle_pct = 73;
        2: idle_pct = 9;
        default: idle_pct = (i % 200 < 100) ? 0 : 73;
      endcase
      case ($urandom_range(0, 23))
        0, 1, 2, 3, 4: f = FUNC_ADD;
        5, 6, 7, 8, 9: f = FUNC_SUB;
        10, 11, 12, 13: f = FUNC_MUL;
        14, 15, 16, 17: f = FUNC_DIV;
        18, 19, 20: f = FUNC_CMP;
        21: f = FuncRsv6;
        22: f = FuncRsv7;
        default: f = FUNC_POW;
      endcase
      a = rand_mag();
      b = ($urandom_range(0, 9) == 0) ? a : rand_mag();
      // power time grows with the exponent, so mostly small ones
      n = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 9);
      send_op(f, a, b, n, $urandom, $urandom, $urandom, $urandom);
    end
    start <= 1'b0;

    // let the checker record the last item before waiting on it
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
